[rtl/core/tpi_pkg.sv]
package tpi_pkg;

  localparam int unsigned TAG_WIDTH     = 24;
  localparam int unsigned TFRAC_BITS    = 32;
  localparam int unsigned DIV_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES    = TFRAC_BITS / DIV_PER_STAGE;
  localparam int unsigned PROD_WIDTH    = 64;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_CROSS = 2'd1,
    KIND_POINT = 2'd2,
    KIND_EDGE  = 2'd3
  } seg_kind_e;

endpackage

[rtl/core/tpi_front.sv]
module tpi_front #(
  parameter int unsigned CW = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [tpi_pkg::TAG_WIDTH-1:0]      face_id_i,
  input  logic [CW-1:0]                      plane_z_i,
  input  logic [CW-1:0]                      vx_i [3],
  input  logic [CW-1:0]                      vy_i [3],
  input  logic [CW-1:0]                      vz_i [3],
  input  logic                               ready_i,
  output logic                               valid_o,
  output logic [tpi_pkg::TAG_WIDTH-1:0]      tag_o,
  output tpi_pkg::seg_kind_e                 kind_o,
  output logic [CW-1:0]                      plane_o,
  output logic [CW-1:0]                      bx_o [2],
  output logic [CW-1:0]                      by_o [2],
  output logic [CW:0]                        dx_o [2],
  output logic [CW:0]                        dy_o [2],
  output logic [CW-1:0]                      num_o [2],
  output logic [CW-1:0]                      den_o [2],
  output logic                               one_o [2]
);

  logic               v_q;
  logic               en;
  logic [2:0]         up_m;
  logic [2:0]         on_m;
  tpi_pkg::seg_kind_e kind_d;
  logic [1:0]         ua [2];
  logic [1:0]         la [2];
  logic [1:0]         pa [2];
  logic [CW-1:0]      bx_d [2];
  logic [CW-1:0]      by_d [2];
  logic [CW:0]        dx_d [2];
  logic [CW:0]        dy_d [2];
  logic [CW-1:0]      num_d [2];
  logic [CW-1:0]      den_d [2];
  logic               one_d [2];

  assign en      = !v_q || ready_i;
  assign stall_o = !en;
  assign valid_o = v_q;

  for (genvar i = 0; i < 3; i++) begin : g_cls
    assign up_m[i] = $signed(vz_i[i]) > $signed(plane_z_i);
    assign on_m[i] = (vz_i[i] == plane_z_i);
  end

  // Pick the vertex pairs: upper vertex in the outer loop, both groups in index order.
  always_comb begin
    kind_d = tpi_pkg::KIND_CROSS;
    ua[0] = 2'd0; la[0] = 2'd0; ua[1] = 2'd0; la[1] = 2'd0;
    pa[0] = 2'd0; pa[1] = 2'd0;
    case (up_m)
      3'b001: begin ua[0] = 2'd0; la[0] = 2'd1; ua[1] = 2'd0; la[1] = 2'd2; end
      3'b010: begin ua[0] = 2'd1; la[0] = 2'd0; ua[1] = 2'd1; la[1] = 2'd2; end
      3'b100: begin ua[0] = 2'd2; la[0] = 2'd0; ua[1] = 2'd2; la[1] = 2'd1; end
      3'b011: begin ua[0] = 2'd0; la[0] = 2'd2; ua[1] = 2'd1; la[1] = 2'd2; end
      3'b101: begin ua[0] = 2'd0; la[0] = 2'd1; ua[1] = 2'd2; la[1] = 2'd1; end
      3'b110: begin ua[0] = 2'd1; la[0] = 2'd0; ua[1] = 2'd2; la[1] = 2'd0; end
      3'b000: begin
        case (on_m)
          3'b001: begin kind_d = tpi_pkg::KIND_POINT; pa[0] = 2'd0; pa[1] = 2'd0; end
          3'b010: begin kind_d = tpi_pkg::KIND_POINT; pa[0] = 2'd1; pa[1] = 2'd1; end
          3'b100: begin kind_d = tpi_pkg::KIND_POINT; pa[0] = 2'd2; pa[1] = 2'd2; end
          3'b011: begin kind_d = tpi_pkg::KIND_EDGE;  pa[0] = 2'd0; pa[1] = 2'd1; end
          3'b101: begin kind_d = tpi_pkg::KIND_EDGE;  pa[0] = 2'd0; pa[1] = 2'd2; end
          3'b110: begin kind_d = tpi_pkg::KIND_EDGE;  pa[0] = 2'd1; pa[1] = 2'd2; end
          default: kind_d = tpi_pkg::KIND_ZERO;
        endcase
      end
      default: kind_d = tpi_pkg::KIND_ZERO;
    endcase
  end

  for (genvar c = 0; c < 2; c++) begin : g_lane
    always_comb begin
      bx_d[c]  = '0;
      by_d[c]  = '0;
      dx_d[c]  = '0;
      dy_d[c]  = '0;
      num_d[c] = '0;
      den_d[c] = {{(CW-1){1'b0}}, 1'b1};
      one_d[c] = 1'b0;
      case (kind_d)
        tpi_pkg::KIND_CROSS: begin
          bx_d[c]  = vx_i[ua[c]];
          by_d[c]  = vy_i[ua[c]];
          dx_d[c]  = {vx_i[la[c]][CW-1], vx_i[la[c]]} - {vx_i[ua[c]][CW-1], vx_i[ua[c]]};
          dy_d[c]  = {vy_i[la[c]][CW-1], vy_i[la[c]]} - {vy_i[ua[c]][CW-1], vy_i[ua[c]]};
          num_d[c] = vz_i[ua[c]] - plane_z_i;
          den_d[c] = vz_i[ua[c]] - vz_i[la[c]];
          one_d[c] = (num_d[c] >= den_d[c]);
        end
        tpi_pkg::KIND_POINT, tpi_pkg::KIND_EDGE: begin
          bx_d[c] = vx_i[pa[c]];
          by_d[c] = vy_i[pa[c]];
        end
        default: begin
          bx_d[c] = '0;
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        bx_o[c]  <= bx_d[c];
        by_o[c]  <= by_d[c];
        dx_o[c]  <= dx_d[c];
        dy_o[c]  <= dy_d[c];
        num_o[c] <= num_d[c];
        den_o[c] <= den_d[c];
        one_o[c] <= one_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_o   <= face_id_i;
      kind_o  <= kind_d;
      plane_o <= plane_z_i;
    end
  end

endmodule

[rtl/core/tpi_div.sv]
module tpi_div #(
  parameter int unsigned CW  = 32,
  parameter int unsigned SBW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [CW-1:0]                 num_i [2],
  input  logic [CW-1:0]                 den_i [2],
  input  logic                          one_i [2],
  input  logic [SBW-1:0]                sb_i,
  input  logic                          ready_i,
  output logic                          valid_o,
  output logic [tpi_pkg::TFRAC_BITS:0]  t_o [2],
  output logic [SBW-1:0]                sb_o
);

  localparam int unsigned NS = tpi_pkg::DIV_STAGES;
  localparam int unsigned QW = tpi_pkg::TFRAC_BITS;

  logic          v_q   [NS];
  logic [CW-1:0] r_q   [NS][2];
  logic [QW-1:0] q_q   [NS][2];
  logic [CW-1:0] den_q [NS][2];
  logic          one_q [NS][2];
  logic [SBW-1:0] sb_q [NS];
  logic [NS:0]   en;

  assign en[NS]  = ready_i;
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign sb_o    = sb_q[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic           src_v;
    logic [CW-1:0]  src_r   [2];
    logic [QW-1:0]  src_q   [2];
    logic [CW-1:0]  src_den [2];
    logic           src_one [2];
    logic [SBW-1:0] src_sb;
    logic [CW-1:0]  r_d [2];
    logic [QW-1:0]  q_d [2];

    assign en[k] = !v_q[k] || en[k+1];

    if (k == 0) begin : g_first
      assign src_v  = valid_i;
      assign src_sb = sb_i;
      for (genvar c = 0; c < 2; c++) begin : g_l
        assign src_r[c]   = num_i[c];
        assign src_q[c]   = '0;
        assign src_den[c] = den_i[c];
        assign src_one[c] = one_i[c];
      end
    end else begin : g_next
      assign src_v  = v_q[k-1];
      assign src_sb = sb_q[k-1];
      for (genvar c = 0; c < 2; c++) begin : g_l
        assign src_r[c]   = r_q[k-1][c];
        assign src_q[c]   = q_q[k-1][c];
        assign src_den[c] = den_q[k-1][c];
        assign src_one[c] = one_q[k-1][c];
      end
    end

    // Restoring division, DIV_PER_STAGE quotient bits per stage; the remainder stays below den while num is below den.
    for (genvar c = 0; c < 2; c++) begin : g_step
      always_comb begin
        logic [CW:0]   r2;
        logic [CW-1:0] r;
        logic [QW-1:0] qq;
        logic          ge;
        r  = src_r[c];
        qq = src_q[c];
        for (int s = 0; s < int'(tpi_pkg::DIV_PER_STAGE); s++) begin
          r2 = {r, 1'b0};
          ge = (r2 >= {1'b0, src_den[c]});
          if (ge) begin
            r2 = r2 - {1'b0, src_den[c]};
          end
          r  = r2[CW-1:0];
          qq = {qq[QW-2:0], ge};
        end
        r_d[c] = r;
        q_d[c] = qq;
      end

      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          r_q[k][c]   <= r_d[c];
          q_q[k][c]   <= q_d[c];
          den_q[k][c] <= src_den[c];
          one_q[k][c] <= src_one[c];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        sb_q[k] <= src_sb;
      end
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_out
    assign t_o[c] = {one_q[NS-1][c], q_q[NS-1][c]};
  end

endmodule

[rtl/core/tpi_mul.sv]
module tpi_mul #(
  parameter int unsigned CW = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [tpi_pkg::TFRAC_BITS:0]      t_i [2],
  input  logic [CW-1:0]                     base_i [4],
  input  logic [CW:0]                       d_i [4],
  input  tpi_pkg::seg_kind_e                kind_i,
  input  logic [tpi_pkg::TAG_WIDTH-1:0]     tag_i,
  input  logic [CW-1:0]                     plane_i,
  input  logic                              stall_i,
  output logic                              valid_o,
  output logic [tpi_pkg::TAG_WIDTH-1:0]     tag_o,
  output tpi_pkg::seg_kind_e                kind_o,
  output logic [CW-1:0]                     res_o [4],
  output logic [CW-1:0]                     z_o
);

  localparam int unsigned PW = tpi_pkg::PROD_WIDTH;
  localparam int unsigned QW = tpi_pkg::TFRAC_BITS;

  logic               v1_q, v2_q;
  logic               en1, en2;
  logic [PW-1:0]      plo_q [4];
  logic [PW-1:0]      phi_q [4];
  logic               neg_q [4];
  logic               one_q [4];
  logic [CW-1:0]      base_q [4];
  logic [CW-1:0]      dlo_q [4];
  tpi_pkg::seg_kind_e kind_q;
  logic [tpi_pkg::TAG_WIDTH-1:0] tag_q;
  logic [CW-1:0]      plane_q;

  assign en2     = !v2_q || !stall_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  for (genvar j = 0; j < 4; j++) begin : g_coord
    logic [CW:0]   mag;
    logic [PW-1:0] mpad;
    logic [QW-1:0] tf;
    logic [PW-1:0] q;
    logic [PW-1:0] sq;
    logic [CW-1:0] off;

    assign mag  = d_i[j][CW] ? (~d_i[j] + 1'b1) : d_i[j];
    assign mpad = PW'(mag);
    assign tf   = t_i[j/2][QW-1:0];

    always_ff @(posedge clk_i) begin
      if (en1) begin
        plo_q[j]  <= PW'(mpad[QW-1:0]) * PW'(tf);
        phi_q[j]  <= PW'(mpad[PW-1:QW]) * PW'(tf);
        neg_q[j]  <= d_i[j][CW];
        one_q[j]  <= t_i[j/2][QW];
        base_q[j] <= base_i[j];
        dlo_q[j]  <= d_i[j][CW-1:0];
      end
    end

    // Floor of a signed product: round a negative product's magnitude up when any fraction bit is set.
    assign q  = phi_q[j] + PW'(plo_q[j][PW-1:QW]);
    assign sq = neg_q[j] ? (~(q + PW'(|plo_q[j][QW-1:0])) + 1'b1) : q;
    assign off = one_q[j] ? dlo_q[j] : sq[CW-1:0];

    always_ff @(posedge clk_i) begin
      if (en2) begin
        res_o[j] <= base_q[j] + off;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      kind_q  <= kind_i;
      tag_q   <= tag_i;
      plane_q <= plane_i;
    end
    if (en2) begin
      kind_o <= kind_q;
      tag_o  <= tag_q;
      z_o    <= (kind_q == tpi_pkg::KIND_ZERO) ? '0 : plane_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

endmodule

[rtl/core/triangle_plane_intersection_top.sv]
// Pipeline: 19 register stages from the input word to the result word.
// Throughput: one triangle per cycle while stall_i is low; the crossing fractions come
// from two dividers pipelined over 16 stages of two quotient bits each, followed by a
// two-stage multiply.
// Every stage holds its word under stall and fills bubbles, so no word is lost or repeated.
// Reset clears only the valid bits of the stages; it is asynchronous and active low.
module triangle_plane_intersection_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [tpi_pkg::TAG_WIDTH-1:0] face_id_i,
  input  logic [COORD_WIDTH-1:0]        plane_z_i,
  input  logic [COORD_WIDTH-1:0]        v0_x_i,
  input  logic [COORD_WIDTH-1:0]        v0_y_i,
  input  logic [COORD_WIDTH-1:0]        v0_z_i,
  input  logic [COORD_WIDTH-1:0]        v1_x_i,
  input  logic [COORD_WIDTH-1:0]        v1_y_i,
  input  logic [COORD_WIDTH-1:0]        v1_z_i,
  input  logic [COORD_WIDTH-1:0]        v2_x_i,
  input  logic [COORD_WIDTH-1:0]        v2_y_i,
  input  logic [COORD_WIDTH-1:0]        v2_z_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [tpi_pkg::TAG_WIDTH-1:0] tag_out_o,
  output logic [1:0]                    seg_kind_o,
  output logic [COORD_WIDTH-1:0]        start_x_o,
  output logic [COORD_WIDTH-1:0]        start_y_o,
  output logic [COORD_WIDTH-1:0]        start_z_o,
  output logic [COORD_WIDTH-1:0]        end_x_o,
  output logic [COORD_WIDTH-1:0]        end_y_o,
  output logic [COORD_WIDTH-1:0]        end_z_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned TW  = tpi_pkg::TAG_WIDTH;
  localparam int unsigned SBW = TW + 2 + CW + 4 * CW + 4 * (CW + 1);

  logic [CW-1:0] vx [3];
  logic [CW-1:0] vy [3];
  logic [CW-1:0] vz [3];

  logic               f_valid, d_ready, d_valid, m_ready;
  logic [TW-1:0]      f_tag, m_tag;
  tpi_pkg::seg_kind_e f_kind, m_kind;
  logic [1:0]         s_kind;
  logic [CW-1:0]      f_plane, s_plane;
  logic [CW-1:0]      f_bx [2];
  logic [CW-1:0]      f_by [2];
  logic [CW:0]        f_dx [2];
  logic [CW:0]        f_dy [2];
  logic [CW-1:0]      f_num [2];
  logic [CW-1:0]      f_den [2];
  logic               f_one [2];
  logic [SBW-1:0]     sb_in, sb_out;
  logic [tpi_pkg::TFRAC_BITS:0] t [2];
  logic [TW-1:0]      s_tag;
  logic [CW-1:0]      s_base [4];
  logic [CW:0]        s_d [4];
  logic [CW-1:0]      res [4];
  logic [CW-1:0]      z;

  assign vx[0] = v0_x_i; assign vy[0] = v0_y_i; assign vz[0] = v0_z_i;
  assign vx[1] = v1_x_i; assign vy[1] = v1_y_i; assign vz[1] = v1_z_i;
  assign vx[2] = v2_x_i; assign vy[2] = v2_y_i; assign vz[2] = v2_z_i;

  tpi_front #(.CW(CW)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .face_id_i, .plane_z_i,
    .vx_i(vx), .vy_i(vy), .vz_i(vz),
    .ready_i(d_ready), .valid_o(f_valid),
    .tag_o(f_tag), .kind_o(f_kind), .plane_o(f_plane),
    .bx_o(f_bx), .by_o(f_by), .dx_o(f_dx), .dy_o(f_dy),
    .num_o(f_num), .den_o(f_den), .one_o(f_one)
  );

  // Everything but the divider operands rides alongside the divider stages.
  assign sb_in = {f_tag, f_kind, f_plane, f_bx[0], f_by[0], f_bx[1], f_by[1],
                  f_dx[0], f_dy[0], f_dx[1], f_dy[1]};

  tpi_div #(.CW(CW), .SBW(SBW)) u_div (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(d_ready),
    .num_i(f_num), .den_i(f_den), .one_i(f_one), .sb_i(sb_in),
    .ready_i(m_ready), .valid_o(d_valid), .t_o(t), .sb_o(sb_out)
  );

  assign {s_tag, s_kind, s_plane, s_base[0], s_base[1], s_base[2], s_base[3],
          s_d[0], s_d[1], s_d[2], s_d[3]} = sb_out;

  tpi_mul #(.CW(CW)) u_mul (
    .clk_i, .rst_ni,
    .valid_i(d_valid), .ready_o(m_ready),
    .t_i(t), .base_i(s_base), .d_i(s_d),
    .kind_i(tpi_pkg::seg_kind_e'(s_kind)), .tag_i(s_tag), .plane_i(s_plane),
    .stall_i, .valid_o,
    .tag_o(m_tag), .kind_o(m_kind), .res_o(res), .z_o(z)
  );

  assign tag_out_o  = m_tag;
  assign seg_kind_o = m_kind;
  assign start_x_o  = res[0];
  assign start_y_o  = res[1];
  assign end_x_o    = res[2];
  assign end_y_o    = res[3];
  assign start_z_o  = z;
  assign end_z_o    = z;

`ifndef SYNTHESIS
  a_zero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (seg_kind_o == tpi_pkg::KIND_ZERO) |->
      (start_x_o == '0) && (start_y_o == '0) && (end_x_o == '0) && (end_y_o == '0)
      && (start_z_o == '0))
    else $error("zero segment carries nonzero coordinates");

  a_point_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (seg_kind_o == tpi_pkg::KIND_POINT) |->
      (start_x_o == end_x_o) && (start_y_o == end_y_o))
    else $error("single vertex segment has two different endpoints");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> f_valid && d_valid && valid_o && stall_i)
    else $error("input stalled while the pipeline has a bubble");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(start_x_o) && $stable(end_y_o))
    else $error("stalled result word changed");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = 32;
  localparam int NUM_RANDOM = 1030;
  localparam int QUIET_TAIL = 200;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [tpi_pkg::TAG_WIDTH-1:0] face_id;
    logic [CW-1:0] plane;
    logic [CW-1:0] vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2;
  } triangle_t;

  typedef struct packed {
    logic [tpi_pkg::TAG_WIDTH-1:0] tag;
    tpi_pkg::seg_kind_e kind;
    logic [CW-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  logic clk_i, rst_ni;
  logic valid_i, stall_o, valid_o, stall_i;
  triangle_t drv;
  logic [tpi_pkg::TAG_WIDTH-1:0] tag_out_o;
  logic [1:0] seg_kind_o;
  logic [CW-1:0] start_x_o, start_y_o, start_z_o, end_x_o, end_y_o, end_z_o;

  triangle_t pending_tris[$];
  segment_t expected_segs[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  bit stim_done = 0;
  bit quiet = 0;

  triangle_plane_intersection_top #(.COORD_WIDTH(CW)) u_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .face_id_i(drv.face_id), .plane_z_i(drv.plane),
    .v0_x_i(drv.vx0), .v0_y_i(drv.vy0), .v0_z_i(drv.vz0),
    .v1_x_i(drv.vx1), .v1_y_i(drv.vy1), .v1_z_i(drv.vz1),
    .v2_x_i(drv.vx2), .v2_y_i(drv.vy2), .v2_z_i(drv.vz2),
    .valid_o, .stall_i, .tag_out_o, .seg_kind_o,
    .start_x_o, .start_y_o, .start_z_o, .end_x_o, .end_y_o, .end_z_o
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Crossing point between an upper and a lower vertex, with the fraction
  // t truncated to 32 bits and the offset floored.
  function automatic logic [CW-1:0] cross_coord(logic signed [CW-1:0] cu,
      logic signed [CW-1:0] cl, logic [32:0] t);
    logic signed [CW:0] d;
    logic signed [CW+34:0] prod;
    d = cl - cu;
    prod = d * $signed({1'b0, t});
    return cu + (prod >>> 32);
  endfunction

  function automatic logic [32:0] cross_fraction(logic signed [CW-1:0] zu,
      logic signed [CW-1:0] zl, logic signed [CW-1:0] pl);
    logic [CW:0] num, den;
    logic [CW+32:0] q;
    num = zu - pl;
    den = zu - zl;
    if (num >= den) return 33'h1_0000_0000;
    q = {num, 32'b0} / den;
    return q[32:0];
  endfunction

  function automatic segment_t slice_triangle(triangle_t tr);
    logic signed [CW-1:0] x[3], y[3], z[3], pl;
    int ups[3], los[3], ons[3];
    int nu, nl, non, a, b;
    segment_t s;
    logic [32:0] t;
    x = '{tr.vx0, tr.vx1, tr.vx2};
    y = '{tr.vy0, tr.vy1, tr.vy2};
    z = '{tr.vz0, tr.vz1, tr.vz2};
    pl = tr.plane;
    nu = 0; nl = 0; non = 0;
    s = '0;
    s.tag = tr.face_id;
    s.kind = tpi_pkg::KIND_ZERO;
    for (int i = 0; i < 3; i++) begin
      if (z[i] > pl) ups[nu++] = i;
      else los[nl++] = i;
      if (z[i] == pl) ons[non++] = i;
    end
    if (nu == 1 || nu == 2) begin
      s.kind = tpi_pkg::KIND_CROSS;
      a = ups[0]; b = los[0];
      t = cross_fraction(z[a], z[b], pl);
      s.sx = cross_coord(x[a], x[b], t);
      s.sy = cross_coord(y[a], y[b], t);
      s.sz = pl;
      if (nu == 1) b = los[1];
      else a = ups[1];
      t = cross_fraction(z[a], z[b], pl);
      s.ex = cross_coord(x[a], x[b], t);
      s.ey = cross_coord(y[a], y[b], t);
      s.ez = pl;
    end else if (nu == 0 && (non == 1 || non == 2)) begin
      a = ons[0];
      b = (non == 2) ? ons[1] : ons[0];
      s.kind = (non == 1) ? tpi_pkg::KIND_POINT : tpi_pkg::KIND_EDGE;
      s.sx = x[a]; s.sy = y[a]; s.sz = z[a];
      s.ex = x[b]; s.ey = y[b]; s.ez = z[b];
    end
    return s;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) - 4;
      3: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic triangle_t rand_triangle();
    triangle_t tr;
    logic [CW-1:0] pl;
    tr = {24'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom};
    tr.vx0 = rand_coord(); tr.vy1 = rand_coord(); tr.vx2 = rand_coord();
    pl = rand_coord();
    tr.plane = pl;
    // Mostly pick heights around the plane so every class of segment shows up.
    if ($urandom_range(0, 3) != 0) begin
      tr.vz0 = ($urandom_range(0, 3) == 0) ? pl : pl + $urandom_range(0, 2000) - 1000;
      tr.vz1 = ($urandom_range(0, 3) == 0) ? pl : pl + $urandom_range(0, 2000) - 1000;
      tr.vz2 = ($urandom_range(0, 3) == 0) ? pl : pl + $urandom_range(0, 2000) - 1000;
    end
    return tr;
  endfunction

  function automatic triangle_t make_tri(logic [CW-1:0] pl, logic [CW-1:0] z0,
      logic [CW-1:0] z1, logic [CW-1:0] z2);
    triangle_t tr;
    tr = rand_triangle();
    tr.plane = pl; tr.vz0 = z0; tr.vz1 = z1; tr.vz2 = z2;
    return tr;
  endfunction

  function automatic void add_tri(triangle_t tr);
    pending_tris.insert(pending_tris.size(), tr);
  endfunction

  initial begin
    triangle_t tr;
    logic [CW-1:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    add_tri(make_tri(0, 5, 6, 7));
    add_tri(make_tri(0, 0, -3, -4));
    add_tri(make_tri(0, -1, 0, 0));
    add_tri(make_tri(0, 0, 0, 0));
    add_tri(make_tri(0, -1, -2, -3));
    add_tri(make_tri(0, 10, -10, -20));
    add_tri(make_tri(0, -10, 10, 20));
    add_tri(make_tri(0, 10, 0, -20));
    add_tri(make_tri(0, 0, 10, 0));
    add_tri(make_tri(mn, mx, mn, mn));
    add_tri(make_tri(mn, mx, mx, mn));
    add_tri(make_tri(mx - 1, mx, mn, mx - 1));
    add_tri(make_tri(mn, mx, mn + 1, mn));
    tr = make_tri(0, mx, mn, mn);
    tr.vx0 = mn; tr.vy0 = mx; tr.vx1 = mx; tr.vy1 = mn; tr.vx2 = mx; tr.vy2 = mn;
    tr.face_id = '1;
    add_tri(tr);
    tr = make_tri(0, mx, mx, mn);
    tr.vx0 = mx; tr.vy0 = mn; tr.vx1 = mx; tr.vy1 = mn; tr.vx2 = mn; tr.vy2 = mx;
    tr.face_id = '0;
    add_tri(tr);
    tr = make_tri(3, 3, 3, 2);
    tr.vx0 = mn; tr.vy0 = mx; tr.vx1 = mx; tr.vy1 = mn;
    add_tri(tr);
    for (int i = 0; i < NUM_RANDOM; i++) add_tri(rand_triangle());
  end

  initial begin
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
  end

  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 0;
      drv <= '0;
    end else if (!valid_i || !stall_o) begin
      if (valid_i) n_sent++;
      if (pending_tris.size() <= QUIET_TAIL) quiet = 1;
      if (src_gap > 0) begin
        src_gap--;
        valid_i <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(1, 17) - 1;
        valid_i <= 0;
      end else if (pending_tris.size() > 0) begin
        drv <= pending_tris[0];
        expected_segs.insert(expected_segs.size(),
                             slice_triangle(pending_tris.pop_front()));
        valid_i <= 1;
      end else begin
        valid_i <= 0;
        stim_done = 1;
      end
    end
  end

  int sink_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    segment_t e;
    if (!rst_ni) begin
      stall_i <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_segs.size() == 0) begin
          $error("unexpected segment word, tag %h", tag_out_o);
          n_errors++;
        end else begin
          e = expected_segs.pop_front();
          n_checked++;
          kind_seen[e.kind]++;
          if (tag_out_o !== e.tag) begin
            $error("tag_out: expected %h, got %h", e.tag, tag_out_o); n_errors++;
          end
          if (seg_kind_o !== e.kind) begin
            $error("seg_kind: expected %0d, got %0d", e.kind, seg_kind_o); n_errors++;
          end
          if (start_x_o !== e.sx) begin
            $error("start_x: expected %h, got %h", e.sx, start_x_o); n_errors++;
          end
          if (start_y_o !== e.sy) begin
            $error("start_y: expected %h, got %h", e.sy, start_y_o); n_errors++;
          end
          if (start_z_o !== e.sz) begin
            $error("start_z: expected %h, got %h", e.sz, start_z_o); n_errors++;
          end
          if (end_x_o !== e.ex) begin
            $error("end_x: expected %h, got %h", e.ex, end_x_o); n_errors++;
          end
          if (end_y_o !== e.ey) begin
            $error("end_y: expected %h, got %h", e.ey, end_y_o); n_errors++;
          end
          if (end_z_o !== e.ez) begin
            $error("end_z: expected %h, got %h", e.ez, end_z_o); n_errors++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        stall_i <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 17) - 1;
        stall_i <= 1;
      end else begin
        stall_i <= 0;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_segs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d triangles, checked %0d segments.", n_sent, n_checked);
    $display("Segment kinds: zero %0d, cross %0d, point %0d, edge %0d.",
             kind_seen[tpi_pkg::KIND_ZERO], kind_seen[tpi_pkg::KIND_CROSS],
             kind_seen[tpi_pkg::KIND_POINT], kind_seen[tpi_pkg::KIND_EDGE]);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[sim.f]
rtl/core/tpi_pkg.sv
rtl/core/tpi_front.sv
rtl/core/tpi_div.sv
rtl/core/tpi_mul.sv
rtl/core/triangle_plane_intersection_top.sv
tb/tb_top.sv
